### design/wrsd_pkg.sv
// Package for the window range settle detector.
// Shared constants, register indexes and the structs passed between the scan core and the top.
// No dependencies.
package wrsd_pkg;

	localparam int WINDOW_MAX = 16;
	localparam int DATA_W     = 32;
	localparam int RANGE_W    = DATA_W + 1;
	localparam int LEN_REG_W  = 5;
	localparam int PTR_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
	localparam int REG_IDX_W  = 2;

	localparam logic [LEN_REG_W-1:0] LEN_RESET    = LEN_REG_W'(8);
	localparam logic [DATA_W-1:0]    THRESH_RESET = DATA_W'(4);
	localparam logic [DATA_W-1:0]    BASE_RESET   = '0;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_WINDOW_LENGTH    = 2'd0,
		REG_STEADY_THRESHOLD = 2'd1,
		REG_BASE_COUNT       = 2'd2
	} reg_idx_t;

	// settings the scan core needs for one item
	typedef struct packed {
		logic [CNT_W-1:0] len_use;
	} cfg_t;

	// window statistics for one item
	typedef struct packed {
		logic               window_full;
		logic [RANGE_W-1:0] window_range;
	} stat_t;

endpackage

### design/wrsd_sample_if.sv
// Input channel: one encoder count per transfer.
// Depends on wrsd_pkg.
interface wrsd_sample_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [wrsd_pkg::DATA_W-1:0]      encoder_count;

	modport source (output valid, output encoder_count, input ready);
	modport sink   (input valid, input encoder_count, output ready);
endinterface

### design/wrsd_result_if.sv
// Result channel: calibration pulse, value, done flag and window statistics.
// Depends on wrsd_pkg.
interface wrsd_result_if;
	logic                                    valid;
	logic                                    ready;
	logic                                    calibrate_now;
	logic signed [wrsd_pkg::DATA_W-1:0]      calibrate_value;
	logic                                    done_res;
	logic                                    window_full;
	logic [wrsd_pkg::RANGE_W-1:0]            window_range;

	modport source (output valid, output calibrate_now, output calibrate_value,
		output done_res, output window_full, output window_range, input ready);
	modport sink   (input valid, input calibrate_now, input calibrate_value,
		input done_res, input window_full, input window_range, output ready);
endinterface

### design/wrsd_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on wrsd_pkg.
interface wrsd_cfg_if;
	logic                                    valid;
	logic                                    ready;
	logic [wrsd_pkg::REG_IDX_W-1:0]          reg_index;
	logic [wrsd_pkg::DATA_W-1:0]             wdata;

	modport source (output valid, output reg_index, output wdata, input ready);
	modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

### design/wrsd_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module wrsd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic                                         re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### design/wrsd_scan.sv
// Scan core: stores each sample in the ring RAM, then walks the window back through
// the RAM one entry a cycle tracking min and max. Depends on wrsd_pkg, wrsd_ram, wrsd_sample_if.
module wrsd_scan (
	input  logic                  clk,
	input  logic                  arst_n,
	input  wrsd_pkg::cfg_t        cfg,
	wrsd_sample_if.sink           smp,
	output logic                  stat_valid,
	input  logic                  stat_ready,
	output wrsd_pkg::stat_t       stat
);

	typedef enum logic [1:0] {S_IDLE, S_READ, S_FIN, S_RES} state_t;

	state_t                              state_q;
	logic [wrsd_pkg::PTR_W-1:0]          wpos_q;
	logic [wrsd_pkg::PTR_W-1:0]          rd_ptr_q;
	logic [wrsd_pkg::CNT_W-1:0]          fill_q;
	logic [wrsd_pkg::CNT_W-1:0]          remain_q;
	logic                                rd_vld_s1;
	logic signed [wrsd_pkg::DATA_W-1:0]  lo_q;
	logic signed [wrsd_pkg::DATA_W-1:0]  hi_q;

	logic                                accept;
	logic                                rd_en;
	logic [wrsd_pkg::DATA_W-1:0]         rd_data;
	logic signed [wrsd_pkg::DATA_W-1:0]  rd_val;
	logic [wrsd_pkg::CNT_W-1:0]          fill_clamp;
	logic [wrsd_pkg::CNT_W-1:0]          fill_new;
	logic [wrsd_pkg::PTR_W-1:0]          wpos_next;
	logic [wrsd_pkg::PTR_W-1:0]          wpos_prev;
	logic [wrsd_pkg::PTR_W-1:0]          rd_ptr_prev;

	assign smp.ready = (state_q == S_IDLE);
	assign accept    = smp.valid && smp.ready;
	assign rd_en     = (state_q == S_READ);
	assign rd_val    = $signed(rd_data);

	// Reads only ever reach older slots of the current item; the next write waits
	// for S_IDLE, so no entry is read and written in overlapping cycles.
	wrsd_ram #(
		.WIDTH (wrsd_pkg::DATA_W),
		.DEPTH (wrsd_pkg::WINDOW_MAX)
	) u_ring (
		.clk   (clk),
		.we    (accept),
		.waddr (wpos_q),
		.wdata (smp.encoder_count),
		.re    (rd_en),
		.raddr (rd_ptr_q),
		.rdata (rd_data)
	);

	always_comb begin
		fill_clamp = (fill_q > cfg.len_use) ? cfg.len_use : fill_q;
		fill_new   = (fill_clamp < cfg.len_use) ? fill_clamp + 1'b1 : fill_clamp;
		wpos_next  = (wpos_q == wrsd_pkg::PTR_W'(wrsd_pkg::WINDOW_MAX - 1)) ? '0
			: wpos_q + 1'b1;
		wpos_prev  = (wpos_q == '0) ? wrsd_pkg::PTR_W'(wrsd_pkg::WINDOW_MAX - 1)
			: wpos_q - 1'b1;
		rd_ptr_prev = (rd_ptr_q == '0) ? wrsd_pkg::PTR_W'(wrsd_pkg::WINDOW_MAX - 1)
			: rd_ptr_q - 1'b1;
	end

	always_comb begin
		stat_valid         = (state_q == S_RES);
		stat.window_full   = (fill_q == cfg.len_use);
		stat.window_range  = {hi_q[wrsd_pkg::DATA_W-1], hi_q}
			- {lo_q[wrsd_pkg::DATA_W-1], lo_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			wpos_q    <= '0;
			fill_q    <= '0;
			remain_q  <= '0;
			rd_ptr_q  <= '0;
			rd_vld_s1 <= 1'b0;
			lo_q      <= '0;
			hi_q      <= '0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (rd_vld_s1) begin
				if (rd_val < lo_q) begin
					lo_q <= rd_val;
				end
				if (rd_val > hi_q) begin
					hi_q <= rd_val;
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						lo_q     <= smp.encoder_count;
						hi_q     <= smp.encoder_count;
						wpos_q   <= wpos_next;
						rd_ptr_q <= wpos_prev;
						fill_q   <= fill_new;
						remain_q <= fill_new - 1'b1;
						state_q  <= (fill_new == wrsd_pkg::CNT_W'(1)) ? S_FIN : S_READ;
					end
				end
				S_READ: begin
					rd_ptr_q <= rd_ptr_prev;
					remain_q <= remain_q - 1'b1;
					if (remain_q == wrsd_pkg::CNT_W'(1)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					// last read data folds in at this edge
					state_q <= S_RES;
				end
				S_RES: begin
					if (stat_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_rd_follows_read: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> $past(state_q) == S_READ)
		else $error("read data returned without a read issued");
	a_lo_not_above_hi: assert property (@(posedge clk) disable iff (!arst_n)
		stat_valid |-> lo_q <= hi_q)
		else $error("window min above max");
	a_fill_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (fill_q != '0 && fill_q <= cfg.len_use))
		else $error("fill count out of range during scan");
`endif

endmodule

### design/window_range_settle_detector_top.sv
// Top level of the window range settle detector: configuration registers, scan core,
// result register and the sticky done flag. Depends on wrsd_pkg, wrsd_scan and the interfaces.
//
// Each encoder count transfer is written into a 16-entry ring RAM and the block then
// walks the window backward through the RAM's single read port, one sample per cycle,
// keeping the running min and max. The walk covers the samples in the window, 1 to
// window_length of them, and a finished core result is held back only while the output
// register still holds a result that is not being taken. The range is the exact 33-bit
// max minus min. When the window holds window_length samples and the range is at most
// steady_threshold, calibrate_now pulses with base_count on calibrate_value and the
// done flag sets until reset. A finished result sits in an output register, so the next
// sample transfer is taken while the result waits. window_length 0 acts as 1, values
// above the maximum act as the maximum; lowering it keeps the newest samples.
// The user must write configuration only while the block is idle; the block itself
// does not enforce this, and the write port is always ready.
// The ring RAM has no reset: only entries written since reset fall inside the window.
module window_range_settle_detector_top (
	input  logic            clk,
	input  logic            arst_n,
	wrsd_sample_if.sink     smp,
	wrsd_result_if.source   res,
	wrsd_cfg_if.sink        cfg
);

	logic [wrsd_pkg::LEN_REG_W-1:0] len_q;
	logic [wrsd_pkg::DATA_W-1:0]    thresh_q;
	logic [wrsd_pkg::DATA_W-1:0]    base_q;
	logic                           done_q;
	logic                           res_valid_q;

	wrsd_pkg::cfg_t                 core_cfg;
	wrsd_pkg::stat_t                stat;
	logic                           stat_valid;
	logic                           stat_ready;
	logic                           cal;

	// config write port never stalls
	assign cfg.ready = 1'b1;

	// length in use: zero means one, clamp to the ring size
	always_comb begin
		if (len_q == '0) begin
			core_cfg.len_use = wrsd_pkg::CNT_W'(1);
		end else if (int'(len_q) > wrsd_pkg::WINDOW_MAX) begin
			core_cfg.len_use = wrsd_pkg::CNT_W'(wrsd_pkg::WINDOW_MAX);
		end else begin
			core_cfg.len_use = wrsd_pkg::CNT_W'(len_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= wrsd_pkg::LEN_RESET;
			thresh_q <= wrsd_pkg::THRESH_RESET;
			base_q   <= wrsd_pkg::BASE_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.reg_index)
				wrsd_pkg::REG_WINDOW_LENGTH:    len_q    <= cfg.wdata[wrsd_pkg::LEN_REG_W-1:0];
				wrsd_pkg::REG_STEADY_THRESHOLD: thresh_q <= cfg.wdata;
				wrsd_pkg::REG_BASE_COUNT:       base_q   <= cfg.wdata;
				default: ;  // unknown index: write dropped
			endcase
		end
	end

	wrsd_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (core_cfg),
		.smp        (smp),
		.stat_valid (stat_valid),
		.stat_ready (stat_ready),
		.stat       (stat)
	);

	// result register takes a new item when empty or being drained
	assign stat_ready = !res_valid_q || res.ready;
	assign cal        = stat.window_full && (stat.window_range <= {1'b0, thresh_q});
	assign res.valid  = res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q         <= 1'b0;
			done_q              <= 1'b0;
			res.calibrate_now   <= 1'b0;
			res.calibrate_value <= '0;
			res.done_res        <= 1'b0;
			res.window_full     <= 1'b0;
			res.window_range    <= '0;
		end else begin
			if (stat_valid && stat_ready) begin
				res_valid_q         <= 1'b1;
				done_q              <= done_q | cal;
				res.calibrate_now   <= cal;
				res.calibrate_value <= cal ? $signed(base_q) : '0;
				res.done_res        <= done_q | cal;
				res.window_full     <= stat.window_full;
				res.window_range    <= stat.window_range;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

`ifndef ASSERT_OFF
	a_cal_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.calibrate_now) |-> (res.window_full && res.done_res))
		else $error("calibrate without full window or done flag");
	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(done_q))
		else $error("done flag cleared outside reset");
	a_value_zero_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.calibrate_now) |-> (res.calibrate_value == '0))
		else $error("calibrate value nonzero without calibrate");
`endif

endmodule
